// File: hdl/rgb2yuv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types, register codes and fixed-point helpers for the RGB to
// YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(768);

  // Signed width of the weighted sums: |sum| < 2^17
  localparam int SUM_W = 18;
  // Quotient after the divide by 256, plus room for the offset add
  localparam int QUO_W = SUM_W - 8;
  localparam int RES_W = QUO_W + 1;

  // BT.601 integer coefficients
  localparam logic signed [SUM_W-1:0] Y_R  = SUM_W'(66);
  localparam logic signed [SUM_W-1:0] Y_G  = SUM_W'(129);
  localparam logic signed [SUM_W-1:0] Y_B  = SUM_W'(25);
  localparam logic signed [SUM_W-1:0] CB_R = -SUM_W'(38);
  localparam logic signed [SUM_W-1:0] CB_G = -SUM_W'(74);
  localparam logic signed [SUM_W-1:0] CB_B = SUM_W'(112);
  localparam logic signed [SUM_W-1:0] CR_R = SUM_W'(112);
  localparam logic signed [SUM_W-1:0] CR_G = -SUM_W'(94);
  localparam logic signed [SUM_W-1:0] CR_B = -SUM_W'(18);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(128);
  localparam logic signed [SUM_W-1:0] DIV_BIAS   = SUM_W'(255);

  localparam logic signed [RES_W-1:0] Y_OFFSET = RES_W'(16);
  localparam logic signed [RES_W-1:0] C_OFFSET = RES_W'(128);
  localparam logic signed [RES_W-1:0] BYTE_MAX = RES_W'(255);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } yuv_t;

  // Frame position flags of one pixel
  typedef struct packed {
    logic chroma_valid;
    logic frame_end;
  } pos_t;

  // Signed divide by 256 truncating toward zero
  function automatic logic signed [QUO_W-1:0] div256_trunc(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] adj;
    adj = v[SUM_W-1] ? v + DIV_BIAS : v;
    return adj[SUM_W-1:8];
  endfunction

  // Saturate to 0..255
  function automatic logic [7:0] clamp_byte(input logic signed [RES_W-1:0] v);
    logic [7:0] res;
    if (v[RES_W-1]) begin
      res = 8'd0;
    end else if (v > BYTE_MAX) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/rgb2yuv_in_if.sv
// ----------------------------------------------------------------------------
// rgb2yuv_in_if
// Valid/ready channel carrying one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface rgb2yuv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hdl/rgb2yuv_out_if.sv
// ----------------------------------------------------------------------------
// rgb2yuv_out_if
// Valid/ready channel carrying one YUV result per transaction.
// ----------------------------------------------------------------------------
interface rgb2yuv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;
  logic       chroma_valid;
  logic       frame_end;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  output chroma_valid, output frame_end, input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  input chroma_valid, input frame_end, output ready);
endinterface

// File: hdl/rgb2yuv_pos_tracker.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pos_tracker
// Frame geometry registers and column/row counters. Gives the position
// flags of the pixel presented now and steps on each accepted pixel.
// ----------------------------------------------------------------------------
module rgb2yuv_pos_tracker #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                            advance,
  output rgb2yuv_pkg::pos_t               pos
);
  import rgb2yuv_pkg::*;

  localparam int CNT_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int CMP_W = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIMENSION);
  localparam logic [CMP_W-1:0] DIM_ONE = CMP_W'(1);

  logic [CFG_W-1:0] width_r, height_r;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CMP_W-1:0] eff_w, eff_h;
  logic             last_col, last_row;

  // Geometry registers; a write takes effect at once, counters untouched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize saturates to the maximum
  function automatic logic [CMP_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (ext == '0) begin
      return DIM_ONE;
    end else if (ext > DIM_MAX) begin
      return DIM_MAX;
    end
    return ext;
  endfunction

  always_comb begin
    eff_w    = eff_dim(width_r);
    eff_h    = eff_dim(height_r);
    last_col = (CMP_W'(col_r) + DIM_ONE) >= eff_w;
    last_row = (CMP_W'(row_r) + DIM_ONE) >= eff_h;

    pos.chroma_valid = !col_r[0] && !row_r[0];
    pos.frame_end    = last_col && last_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    advance && pos.frame_end |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap after frame end");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !last_col |=> col_r == CNT_W'($past(col_r) + 1'b1) && $stable(row_r))
    else $error("column counter did not step");
`endif

endmodule

// File: hdl/rgb2yuv_color_math.sv
// ----------------------------------------------------------------------------
// rgb2yuv_color_math
// BT.601 integer color transform of one pixel: constant-coefficient sums,
// truncating divide by 256, offset and clamp. Chroma forced to zero off
// the 2x2 sampling grid.
// ----------------------------------------------------------------------------
module rgb2yuv_color_math (
  input  rgb2yuv_pkg::pixel_t px,
  input  logic                chroma_valid,
  output rgb2yuv_pkg::yuv_t   yuv
);
  import rgb2yuv_pkg::*;

  logic signed [SUM_W-1:0] r_s, g_s, b_s;
  logic signed [SUM_W-1:0] y_sum, cb_sum, cr_sum;
  logic signed [RES_W-1:0] y_res, cb_res, cr_res;

  always_comb begin
    r_s = $signed({{(SUM_W-8){1'b0}}, px.red});
    g_s = $signed({{(SUM_W-8){1'b0}}, px.green});
    b_s = $signed({{(SUM_W-8){1'b0}}, px.blue});

    y_sum  = Y_R  * r_s + Y_G  * g_s + Y_B  * b_s + ROUND_HALF;
    cb_sum = CB_R * r_s + CB_G * g_s + CB_B * b_s + ROUND_HALF;
    cr_sum = CR_R * r_s + CR_G * g_s + CR_B * b_s + ROUND_HALF;

    y_res  = RES_W'(div256_trunc(y_sum))  + Y_OFFSET;
    cb_res = RES_W'(div256_trunc(cb_sum)) + C_OFFSET;
    cr_res = RES_W'(div256_trunc(cr_sum)) + C_OFFSET;

    yuv.luma        = clamp_byte(y_res);
    yuv.chroma_blue = chroma_valid ? clamp_byte(cb_res) : 8'd0;
    yuv.chroma_red  = chroma_valid ? clamp_byte(cr_res) : 8'd0;
  end

endmodule

// File: hdl/rgb_to_yuv420_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// RGB pixel stream to YUV 4:2:0 (BT.601 integer), one result per pixel,
// chroma taken from the top-left pixel of each 2x2 block.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------------
//   in_ch   | in  | valid / ready      | red, green, blue
//   out_ch  | out | valid / ready      | luma, chroma_blue, chroma_red,
//           |     |                    | chroma_valid, frame_end
//   cfg     | in  | cfg_we (no ready)  | cfg_index, cfg_wdata
//
// One pixel per clock sustained while out_ch is not stalled. The pixel enters the
// input register when it is accepted and then moves on to the result register,
// which drives out_ch.
// The color transform sits between those two registers.
// Reset (rst_n, synchronous) empties both stages, zeroes the counters and
// loads 1024x768 geometry.
// in_ch.ready drops only while both stages are full and out_ch is stalled.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rgb2yuv_in_if.sink                        in_ch,
  rgb2yuv_out_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]     cfg_wdata
);
  import rgb2yuv_pkg::*;

  logic   s1_v_r;
  pixel_t s1_px_r;
  pos_t   s1_pos_r;
  logic   out_v_r;
  yuv_t   out_yuv_r;
  pos_t   out_pos_r;

  logic   out_free, in_rdy, in_take;
  pixel_t in_px;
  pos_t   cur_pos;
  yuv_t   yuv;

  // Stage handshake: each stage loads when it is empty or drains this cycle
  assign out_free = !out_v_r || out_ch.ready;
  assign in_rdy   = !s1_v_r || out_free;
  assign in_take  = in_ch.valid && in_rdy;

  assign in_px.red   = in_ch.red;
  assign in_px.green = in_ch.green;
  assign in_px.blue  = in_ch.blue;

  rgb2yuv_pos_tracker #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .advance  (in_take),
    .pos      (cur_pos)
  );

  rgb2yuv_color_math u_math (
    .px          (s1_px_r),
    .chroma_valid(s1_pos_r.chroma_valid),
    .yuv         (yuv)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_rdy) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_px_r  <= in_px;
      s1_pos_r <= cur_pos;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_v_r) begin
      out_yuv_r <= yuv;
      out_pos_r <= s1_pos_r;
    end
  end

  assign in_ch.ready         = in_rdy;
  assign out_ch.valid        = out_v_r;
  assign out_ch.luma         = out_yuv_r.luma;
  assign out_ch.chroma_blue  = out_yuv_r.chroma_blue;
  assign out_ch.chroma_red   = out_yuv_r.chroma_red;
  assign out_ch.chroma_valid = out_pos_r.chroma_valid;
  assign out_ch.frame_end    = out_pos_r.frame_end;

`ifndef ASSERT_OFF
  a_chroma_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.chroma_valid |->
      out_ch.chroma_blue == 8'd0 && out_ch.chroma_red == 8'd0)
    else $error("chroma not zero off the sampling grid");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_ch.ready |=> s1_v_r && $stable(s1_px_r) && $stable(s1_pos_r))
    else $error("input stage lost its pixel under stall");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && out_v_r && !out_ch.ready)
    else $error("input stalled while pipeline had room");
`endif

endmodule

// File: tb/yuv_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_stream_checker
// Watches the pixel, result and register ports of the RGB to YUV 4:2:0
// converter. It tracks frame geometry and position on its own and works out
// the YUV result of every accepted pixel. Each result transaction is compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module yuv_stream_checker #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rgb2yuv_in_if                             pix,
  rgb2yuv_out_if                            yuv,
  input  logic                              cfg_we,
  input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                error_count,
  output int                                pending_count,
  output int                                checked_count,
  output int                                chroma_count,
  output int                                frame_end_count
);
  import rgb2yuv_pkg::*;

  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    yuv_t color;
    pos_t flags;
  } yuv_result_t;

  yuv_result_t      expected_yuv[$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int               col_pos;
  int               row_pos;
  int               errors;
  int               checked;
  int               chroma_seen;
  int               frame_ends;

  // Register value as the converter uses it: 0 acts as 1, big values saturate
  function automatic int clip_dim(input logic [CFG_W-1:0] v);
    int d;
    d = int'(v);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic logic [7:0] saturate_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // BT.601 integer transform; chroma only on the top-left pixel of a 2x2 block
  function automatic yuv_result_t convert_pixel(input pixel_t px, input bit chroma_on,
                                                input bit last_px);
    int          r;
    int          g;
    int          b;
    yuv_result_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    // int division truncates toward zero, as the block requires
    res.color.luma = saturate_byte((66 * r + 129 * g + 25 * b + 128) / 256 + 16);
    if (chroma_on) begin
      res.color.chroma_blue = saturate_byte((-38 * r - 74 * g + 112 * b + 128) / 256 + 128);
      res.color.chroma_red  = saturate_byte((112 * r - 94 * g - 18 * b + 128) / 256 + 128);
    end else begin
      res.color.chroma_blue = 8'd0;
      res.color.chroma_red  = 8'd0;
    end
    res.flags.chroma_valid = chroma_on;
    res.flags.frame_end    = last_px;
    return res;
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $error("%s", what);
    end else if (errors == REPORT_LIMIT + 1) begin
      $display("further mismatch reports suppressed");
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      flag_error($sformatf("%s mismatch: expected %0d, actual %0d", name, want, got));
    end
  endtask

  // Sample all ports at the clock edge, in the order result, pixel, register
  always @(posedge clk) begin : watch
    yuv_result_t want;
    pixel_t      px;
    bit          last_col;
    bit          last_row;
    if (!rst_n) begin
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      col_pos    = 0;
      row_pos    = 0;
      expected_yuv.delete();
    end else begin
      // result transaction against the oldest prediction
      if (yuv.valid === 1'b1 && yuv.ready === 1'b1) begin
        if (expected_yuv.size() == 0) begin
          flag_error("result transaction with no pixel pending");
        end else begin
          want = expected_yuv.pop_front();
          check_field("luma", want.color.luma, yuv.luma);
          check_field("chroma_blue", want.color.chroma_blue, yuv.chroma_blue);
          check_field("chroma_red", want.color.chroma_red, yuv.chroma_red);
          check_field("chroma_valid", want.flags.chroma_valid, yuv.chroma_valid);
          check_field("frame_end", want.flags.frame_end, yuv.frame_end);
          checked++;
          if (want.flags.chroma_valid) chroma_seen++;
          if (want.flags.frame_end) frame_ends++;
        end
      end

      // pixel transaction: predict, then step the frame position
      if (pix.valid === 1'b1 && pix.ready === 1'b1) begin
        px       = '{pix.red, pix.green, pix.blue};
        last_col = (col_pos + 1 >= clip_dim(width_reg));
        last_row = (row_pos + 1 >= clip_dim(height_reg));
        want     = convert_pixel(px, col_pos[0] == 1'b0 && row_pos[0] == 1'b0,
                                 last_col && last_row);
        expected_yuv.push_back(want);
        if (last_col) begin
          col_pos = 0;
          row_pos = last_row ? 0 : row_pos + 1;
        end else begin
          col_pos++;
        end
      end

      // register write; position counters are left alone
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg  = cfg_wdata;
          CFG_FRAME_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
    end

    error_count     <= errors;
    pending_count   <= expected_yuv.size();
    checked_count   <= checked;
    chroma_count    <= chroma_seen;
    frame_end_count <= frame_ends;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the RGB to YUV 4:2:0 converter. A short directed
// set of colors runs at reset geometry, then a series of frame sizes covers
// zero, oversized and shrunk-mid-frame dimensions and writes to unused
// register slots, then random frames with random pixels. Both channels idle
// in random bursts except in the final stretch.
// ----------------------------------------------------------------------------
module testbench;
  import rgb2yuv_pkg::*;

  localparam int MAX_DIM        = 4096;
  localparam int PIXEL_TARGET   = 850;
  localparam int QUIET_FROM     = 750;
  localparam int WATCHDOG_LIMIT = 2000;

  // Register slots past the defined ones; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  // Extremes and truncation corner cases (small negative chroma sums)
  localparam int SWATCH_N = 11;
  localparam pixel_t SWATCHES [SWATCH_N] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h0A0000, 24'h000A00, 24'h000001
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rgb2yuv_in_if  pix_if();
  rgb2yuv_out_if yuv_if();

  int error_count;
  int pending_count;
  int checked_count;
  int chroma_count;
  int frame_end_count;

  int pixels_sent    = 0;
  int geometry_count = 0;
  int stall_pct      = 0;
  int gap_pct        = 0;
  int idle_cycles    = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  rgb_to_yuv420_converter #(
    .MAX_DIMENSION(MAX_DIM)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pix_if),
    .out_ch   (yuv_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  yuv_stream_checker #(
    .MAX_DIM(MAX_DIM)
  ) stream_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix            (pix_if),
    .yuv            (yuv_if),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .chroma_count   (chroma_count),
    .frame_end_count(frame_end_count)
  );

  // Watchdog: cycles out of reset with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (pix_if.valid && pix_if.ready) || (yuv_if.valid && yuv_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    yuv_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        yuv_if.ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 5);
        yuv_if.ready <= 1'b0;
      end else begin
        yuv_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int clip_dim(input int v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // One pixel transaction, then maybe an idle gap with valid low
  task automatic send_pixel(input pixel_t px);
    int gap;
    // final stretch runs with no idling on either side
    if (pixels_sent >= QUIET_FROM) begin
      stall_pct = 0;
      gap_pct   = 0;
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= px.red;
    pix_if.green <= px.green;
    pix_if.blue  <= px.blue;
    @(posedge clk);
    while (pix_if.ready !== 1'b1) @(posedge clk);
    pixels_sent++;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 6);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel('{pick_level(), pick_level(), pick_level()});
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle_pipeline();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_pressure();
    if (pixels_sent >= QUIET_FROM) begin
      stall_pct = 0;
      gap_pct   = 0;
    end else begin
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 25;
    end
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    settle_pipeline();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    geometry_count++;
    pick_pressure();
  endtask

  initial begin : stimulus
    int w;
    int h;
    int area;
    int count;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_FRAME_WIDTH;
    cfg_wdata    <= '0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed colors at reset geometry, each on an even then an odd column
    geometry_count = 1;
    pick_pressure();
    for (int i = 0; i < SWATCH_N; i++) begin
      send_pixel(SWATCHES[i]);
      send_pixel(SWATCHES[i]);
    end

    // Oversized registers saturate to the maximum dimension
    set_geometry(13'h1FFF, 13'h1FFF);
    send_random(10);

    // Shrink mid-row: the column is already past the new width
    set_geometry(13'd3, 13'd2);
    send_random(14);

    // Tall narrow frame, then shrink so the row is past the new height
    set_geometry(13'd2, 13'd4096);
    send_random(11);
    set_geometry(13'd2, 13'd3);
    send_random(8);

    // Writes to unused slots leave the geometry alone
    settle_pipeline();
    write_reg(CFG_SPARE_A, 13'h1FFF);
    write_reg(CFG_SPARE_B, 13'h0000);
    send_random(6);

    // Single column and single row frames
    set_geometry(13'd1, 13'd4096);
    send_random(8);
    set_geometry(13'd4096, 13'd1);
    send_random(8);

    // Zero dimensions act as a 1x1 frame
    set_geometry(13'd0, 13'd0);
    send_random(6);

    // Random geometries, mostly small whole frames with random content
    while (pixels_sent < PIXEL_TARGET) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 9);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 6);
      set_geometry(CFG_W'(w), CFG_W'(h));
      area = clip_dim(w) * clip_dim(h);
      if (area <= 64) begin
        count = area * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area);
      end else begin
        count = $urandom_range(4, 40);
      end
      // stop close to the pixel target
      if (count > PIXEL_TARGET - pixels_sent) count = PIXEL_TARGET - pixels_sent;
      send_random(count);
    end

    settle_pipeline();
    repeat (5) @(posedge clk);

    $display("Run covered %0d pixels over %0d frame geometries.", pixels_sent,
             geometry_count);
    $display("Checked %0d results: %0d carried chroma, %0d ended a frame.", checked_count,
             chroma_count, frame_end_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
